// File: rtl/core/xorshift_uniform_range_generator_macros.svh
// assertion macros shared by the generator's checker
`ifndef XORSHIFT_UNIFORM_RANGE_GENERATOR_MACROS_SVH
`define XORSHIFT_UNIFORM_RANGE_GENERATOR_MACROS_SVH

// consequent checked in the same cycle as the antecedent
`define XURG_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("xurg assertion failed");

// consequent checked from the next cycle on
`define XURG_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> cons) \
        else $error("xurg assertion failed");

`endif

// File: rtl/core/xurg_pkg.sv
// shared types and constants of the xorshift range generator
package xurg_pkg;

    localparam int unsigned BOUND_W = 32;
    localparam int unsigned WORD_W  = 64;
    localparam int unsigned HALF_W  = 32;
    localparam int unsigned RANGE_W = 33;

    localparam logic [WORD_W-1:0] GOLDEN   = 64'h9E37_79B9_7F4A_7C15;
    localparam logic [WORD_W-1:0] MIX1     = 64'hBF58_476D_1CE4_E5B9;
    localparam logic [WORD_W-1:0] MIX2     = 64'h94D0_49BB_1331_11EB;
    localparam logic [WORD_W-1:0] FALLBACK = 64'h0000_0000_F39A_3E2D;
    localparam logic [WORD_W-1:0] STAR     = 64'h2545_F491_4F6C_DD1D;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_LIMIT_DIV,
        S_LIMIT_SET,
        S_SEED_INIT,
        S_FOLD,
        S_MIX_ADD,
        S_MUL1,
        S_MIX_XS27,
        S_MUL2,
        S_MIX_FINAL,
        S_XSHIFT,
        S_DRAW_MUL,
        S_DRAW_CHECK,
        S_DRAW_DIV,
        S_RESULT
    } t_state;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_LIMIT_INIT,
        OP_DIV_STEP,
        OP_SET_LIMIT,
        OP_FOLD_INIT,
        OP_FOLD_STEP,
        OP_MIX_ADD,
        OP_MIX_XS27,
        OP_MIX_FINAL,
        OP_XORSHIFT,
        OP_DRAW_INIT,
        OP_RESULT
    } t_op;

    typedef enum logic [1:0] {
        PART_LL,
        PART_HL,
        PART_LH
    } t_part;

    typedef enum logic [1:0] {
        MC_MIX1,
        MC_MIX2,
        MC_STAR
    } t_mconst;

    typedef enum logic [1:0] {
        ACC_NONE,
        ACC_SET,
        ACC_ADD_HI
    } t_acc;

    typedef struct packed {
        t_op     op;
        logic    mul_en;
        t_part   part;
        t_mconst mconst;
        t_acc    acc;
    } t_cmd;

    typedef struct packed {
        logic degen;
        logic seeded;
        logic reject;
        logic out_free;
    } t_status;

endpackage

// File: rtl/core/xorshift_uniform_range_generator.sv
// top level of the xorshift64* uniform range generator
// Each request word carries inclusive bounds; the block answers with one word
// holding a uniform value in [lower, upper], or the lower bound when lower >= upper.
// Requests are handled one at a time. A degenerate request goes straight to the
// result. Otherwise the block first sets the rejection limit, then each draw takes a
// state update, a multiply and a limit check, and the kept draw also takes the
// remainder. Limit and remainder are both set by the radix-2 serial divider, which
// produces one quotient bit per cycle. The first draw after reset also seeds the
// generator from entropy_seed (8 fold steps, two 64-bit multiplies built from 32x32
// partial products on the shared multiplier). A finished result sits in an output
// register, so the next request can be taken while it waits.
module xorshift_uniform_range_generator #(
    parameter int unsigned DRAW_BITS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [63:0] i_cfg_wdata,       // entropy_seed
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [63:0] i_s_axis_tdata,    // [31:0] lower_bound, [63:32] upper_bound
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata     // [31:0] random_value
);
    import xurg_pkg::*;

    t_cmd    w_cmd;
    t_status w_status;

    xurg_ctrl #(
        .DRAW_BITS (DRAW_BITS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    xurg_dp #(
        .DRAW_BITS (DRAW_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_req_data  (i_s_axis_tdata),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .i_out_ready (i_m_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .o_out_data  (o_m_axis_tdata)
    );

endmodule

// File: rtl/core/xurg_dp.sv
// datapath: generator state, seed mixer, shared multiplier, serial divider, output word
module xurg_dp #(
    parameter int unsigned DRAW_BITS = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [xurg_pkg::WORD_W-1:0]         i_cfg_wdata,
    input  logic [2*xurg_pkg::BOUND_W-1:0]      i_req_data,
    input  xurg_pkg::t_cmd                      i_cmd,
    output xurg_pkg::t_status                   o_status,
    input  logic                                i_out_ready,
    output logic                                o_out_valid,
    output logic [xurg_pkg::BOUND_W-1:0]        o_out_data
);
    import xurg_pkg::*;

    logic [WORD_W-1:0]    r_seed;
    logic [WORD_W-1:0]    r_gen;
    logic [WORD_W-1:0]    r_work;
    logic [WORD_W-1:0]    r_fold;
    logic [WORD_W-1:0]    r_prod;
    logic [WORD_W-1:0]    r_acc;
    logic [BOUND_W-1:0]   r_lo;
    logic [RANGE_W-1:0]   r_range;
    logic [BOUND_W-1:0]   r_rem;
    logic [DRAW_BITS:0]   r_dvd;
    logic [DRAW_BITS:0]   r_limit;
    logic                 r_degen;
    logic                 r_out_valid;
    logic [BOUND_W-1:0]   r_out_data;

    logic [BOUND_W-1:0]   req_lo;
    logic [BOUND_W-1:0]   req_hi;
    logic [WORD_W-1:0]    mul_a;
    logic [WORD_W-1:0]    mul_b;
    logic [HALF_W-1:0]    op_a;
    logic [HALF_W-1:0]    op_b;
    logic [WORD_W-1:0]    w_prod;
    logic [RANGE_W-1:0]   div_tmp;
    logic [RANGE_W-1:0]   div_sub;
    logic [BOUND_W-1:0]   rem_next;
    logic [DRAW_BITS-1:0] draw;
    logic [DRAW_BITS:0]   pow_d;
    logic [RANGE_W-1:0]   rem_wide;
    logic [WORD_W-1:0]    xs1;
    logic [WORD_W-1:0]    xs2;
    logic [WORD_W-1:0]    xs3;
    logic [WORD_W-1:0]    mix_sum;
    logic [WORD_W-1:0]    fin;

    assign req_lo = i_req_data[BOUND_W-1:0];
    assign req_hi = i_req_data[2*BOUND_W-1:BOUND_W];

    // one 32x32 multiplier, 64-bit products are built from three partial products
    always_comb begin
        case (i_cmd.mconst)
            MC_MIX1: mul_b = MIX1;
            MC_MIX2: mul_b = MIX2;
            MC_STAR: mul_b = STAR;
            default: mul_b = STAR;
        endcase
        mul_a = (i_cmd.mconst == MC_STAR) ? r_gen : r_work;
        case (i_cmd.part)
            PART_LL: begin
                op_a = mul_a[HALF_W-1:0];
                op_b = mul_b[HALF_W-1:0];
            end
            PART_HL: begin
                op_a = mul_a[WORD_W-1:HALF_W];
                op_b = mul_b[HALF_W-1:0];
            end
            PART_LH: begin
                op_a = mul_a[HALF_W-1:0];
                op_b = mul_b[WORD_W-1:HALF_W];
            end
            default: begin
                op_a = mul_a[HALF_W-1:0];
                op_b = mul_b[HALF_W-1:0];
            end
        endcase
    end

    assign w_prod = {{HALF_W{1'b0}}, op_a} * {{HALF_W{1'b0}}, op_b};

    // restoring division, one dividend bit per cycle
    assign div_tmp  = {r_rem, r_dvd[DRAW_BITS]};
    assign div_sub  = div_tmp - r_range;
    assign rem_next = (div_tmp >= r_range) ? div_sub[BOUND_W-1:0] : div_tmp[BOUND_W-1:0];

    assign draw     = r_prod[DRAW_BITS-1:0];
    assign pow_d    = {1'b1, {DRAW_BITS{1'b0}}};
    assign rem_wide = {1'b0, r_rem};

    assign xs1     = r_gen ^ (r_gen >> 12);
    assign xs2     = xs1 ^ (xs1 << 25);
    assign xs3     = xs2 ^ (xs2 >> 27);
    assign mix_sum = (r_seed ^ r_fold) + GOLDEN;
    assign fin     = r_acc ^ (r_acc >> 31);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed      <= '0;
            r_gen       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_seed <= i_cfg_wdata;
            end
            if (i_cmd.op == OP_RESULT) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cmd.op == OP_MIX_FINAL) begin
                r_gen <= (fin == '0) ? FALLBACK : fin;
            end else if (i_cmd.op == OP_XORSHIFT) begin
                r_gen <= xs3;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_en) begin
            r_prod <= w_prod;
        end
        case (i_cmd.acc)
            ACC_SET:    r_acc <= r_prod;
            ACC_ADD_HI: r_acc <= r_acc + {r_prod[HALF_W-1:0], {HALF_W{1'b0}}};
            default:    r_acc <= r_acc;
        endcase
        case (i_cmd.op)
            OP_LOAD: begin
                r_lo    <= req_lo;
                r_range <= {1'b0, req_hi} - {1'b0, req_lo} + RANGE_W'(1);
                r_rem   <= '0;
                r_degen <= (req_lo >= req_hi);
            end
            OP_LIMIT_INIT: begin
                r_dvd <= pow_d;
                r_rem <= '0;
            end
            OP_DRAW_INIT: begin
                r_dvd <= {1'b0, draw};
                r_rem <= '0;
            end
            OP_DIV_STEP: begin
                r_rem <= rem_next;
                r_dvd <= {r_dvd[DRAW_BITS-1:0], 1'b0};
            end
            OP_SET_LIMIT: begin
                // a range wider than the draw leaves zero here: no rejection
                r_limit <= pow_d - rem_wide[DRAW_BITS:0];
            end
            OP_FOLD_INIT: begin
                r_work <= r_seed;
                r_fold <= '0;
            end
            OP_FOLD_STEP: begin
                r_fold <= (r_fold << 8) ^ {{(WORD_W-8){1'b0}}, r_work[7:0]};
                r_work <= (r_work >> 8) ^ (r_work << 5);
            end
            OP_MIX_ADD: begin
                r_work <= mix_sum ^ (mix_sum >> 30);
            end
            OP_MIX_XS27: begin
                r_work <= r_acc ^ (r_acc >> 27);
            end
            OP_RESULT: begin
                r_out_data <= r_lo + r_rem;
            end
            default: begin
                r_lo <= r_lo;
            end
        endcase
    end

    assign o_status.degen    = r_degen;
    assign o_status.seeded   = (r_gen != '0);
    assign o_status.reject   = (r_limit != '0) && ({1'b0, draw} >= r_limit);
    assign o_status.out_free = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

// File: rtl/core/xurg_ctrl.sv
// controller: sequences seeding, rejection draws and serial division per request
module xurg_ctrl #(
    parameter int unsigned DRAW_BITS = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  xurg_pkg::t_status i_status,
    output xurg_pkg::t_cmd    o_cmd
);
    import xurg_pkg::*;

    localparam int unsigned    CNT_W     = $clog2(DRAW_BITS + 1);
    localparam logic [CNT_W-1:0] DIV_LAST  = CNT_W'(DRAW_BITS);
    localparam logic [CNT_W-1:0] FOLD_LAST = CNT_W'(7);
    localparam logic [CNT_W-1:0] MUL_LAST  = CNT_W'(3);

    t_state           r_fsm;
    t_state           n_fsm;
    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] n_cnt;

    // product of step k is accumulated in step k+1
    function automatic t_cmd mul_cmd(input logic [1:0] step, input t_mconst mc);
        t_cmd c;
        c = '{op: OP_NONE, mul_en: 1'b0, part: PART_LL, mconst: mc, acc: ACC_NONE};
        case (step)
            2'd0: begin
                c.mul_en = 1'b1;
                c.part   = PART_LL;
            end
            2'd1: begin
                c.mul_en = 1'b1;
                c.part   = PART_HL;
                c.acc    = ACC_SET;
            end
            2'd2: begin
                c.mul_en = 1'b1;
                c.part   = PART_LH;
                c.acc    = ACC_ADD_HI;
            end
            default: begin
                c.acc = ACC_ADD_HI;
            end
        endcase
        return c;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fsm <= S_IDLE;
            r_cnt <= '0;
        end else begin
            r_fsm <= n_fsm;
            r_cnt <= n_cnt;
        end
    end

    always_comb begin
        n_fsm      = r_fsm;
        n_cnt      = r_cnt;
        o_in_ready = 1'b0;
        o_cmd      = '{op: OP_NONE, mul_en: 1'b0, part: PART_LL, mconst: MC_STAR,
                       acc: ACC_NONE};
        case (r_fsm)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.op = OP_LOAD;
                    n_fsm    = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_status.degen) begin
                    n_fsm = S_RESULT;
                end else begin
                    o_cmd.op = OP_LIMIT_INIT;
                    n_cnt    = '0;
                    n_fsm    = S_LIMIT_DIV;
                end
            end
            S_LIMIT_DIV: begin
                o_cmd.op = OP_DIV_STEP;
                n_cnt    = r_cnt + 1'b1;
                if (r_cnt == DIV_LAST) begin
                    n_fsm = S_LIMIT_SET;
                end
            end
            S_LIMIT_SET: begin
                o_cmd.op = OP_SET_LIMIT;
                n_fsm    = i_status.seeded ? S_XSHIFT : S_SEED_INIT;
            end
            S_SEED_INIT: begin
                o_cmd.op = OP_FOLD_INIT;
                n_cnt    = '0;
                n_fsm    = S_FOLD;
            end
            S_FOLD: begin
                o_cmd.op = OP_FOLD_STEP;
                n_cnt    = r_cnt + 1'b1;
                if (r_cnt == FOLD_LAST) begin
                    n_fsm = S_MIX_ADD;
                end
            end
            S_MIX_ADD: begin
                o_cmd.op = OP_MIX_ADD;
                n_cnt    = '0;
                n_fsm    = S_MUL1;
            end
            S_MUL1: begin
                o_cmd = mul_cmd(r_cnt[1:0], MC_MIX1);
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == MUL_LAST) begin
                    n_fsm = S_MIX_XS27;
                end
            end
            S_MIX_XS27: begin
                o_cmd.op = OP_MIX_XS27;
                n_cnt    = '0;
                n_fsm    = S_MUL2;
            end
            S_MUL2: begin
                o_cmd = mul_cmd(r_cnt[1:0], MC_MIX2);
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == MUL_LAST) begin
                    n_fsm = S_MIX_FINAL;
                end
            end
            S_MIX_FINAL: begin
                o_cmd.op = OP_MIX_FINAL;
                n_fsm    = S_XSHIFT;
            end
            S_XSHIFT: begin
                o_cmd.op = OP_XORSHIFT;
                n_fsm    = S_DRAW_MUL;
            end
            S_DRAW_MUL: begin
                // only the low half of the product reaches the draw
                o_cmd.mul_en = 1'b1;
                o_cmd.part   = PART_LL;
                o_cmd.mconst = MC_STAR;
                n_fsm        = S_DRAW_CHECK;
            end
            S_DRAW_CHECK: begin
                if (i_status.reject) begin
                    n_fsm = S_XSHIFT;
                end else begin
                    o_cmd.op = OP_DRAW_INIT;
                    n_cnt    = '0;
                    n_fsm    = S_DRAW_DIV;
                end
            end
            S_DRAW_DIV: begin
                o_cmd.op = OP_DIV_STEP;
                n_cnt    = r_cnt + 1'b1;
                if (r_cnt == DIV_LAST) begin
                    n_fsm = S_RESULT;
                end
            end
            S_RESULT: begin
                if (i_status.out_free) begin
                    o_cmd.op = OP_RESULT;
                    n_fsm    = S_IDLE;
                end
            end
            default: begin
                n_fsm = S_IDLE;
            end
        endcase
    end

endmodule

// File: rtl/core/xurg_chk.sv
// port-level checker for the range generator, bound to the top level
`include "xorshift_uniform_range_generator_macros.svh"

module xurg_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_axis_tvalid,
    input logic        o_s_axis_tready,
    input logic [63:0] i_s_axis_tdata,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [31:0] o_m_axis_tdata
);

    // a stalled result word holds
    `XURG_ASSERT_NEXT(a_out_hold, o_m_axis_tvalid && !i_m_axis_tready, (o_m_axis_tvalid && $stable(o_m_axis_tdata)))

    // one request at a time
    `XURG_ASSERT_NEXT(a_busy_after_accept, i_s_axis_tvalid && o_s_axis_tready, (!o_s_axis_tready))

    // no result appears in the cycle right after a request is taken
    `XURG_ASSERT_NEXT(a_no_instant_result, i_s_axis_tvalid && o_s_axis_tready, (!$rose(o_m_axis_tvalid)))

    // degenerate bounds accepted while no result waits return the lower bound
    `XURG_ASSERT_NEXT(a_degenerate_lower, i_s_axis_tvalid && o_s_axis_tready && !o_m_axis_tvalid && (i_s_axis_tdata[31:0] >= i_s_axis_tdata[63:32]), ##2 (o_m_axis_tvalid && (o_m_axis_tdata == $past(i_s_axis_tdata[31:0], 3))))

endmodule

bind xorshift_uniform_range_generator xurg_chk u_xurg_chk (.*);

// File: tb/tb.sv
// self-checking testbench for the xorshift64* uniform range generator
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned DRAW_BITS = 32;
    localparam int CYCLE_LIMIT   = 600000;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 200;
    localparam int REPORT_MAX    = 10;

    localparam bit [63:0] GOLDEN_GAMMA  = 64'h9E37_79B9_7F4A_7C15;
    localparam bit [63:0] MIX_MULT_A    = 64'hBF58_476D_1CE4_E5B9;
    localparam bit [63:0] MIX_MULT_B    = 64'h94D0_49BB_1331_11EB;
    localparam bit [63:0] FALLBACK_SEED = 64'h0000_0000_F39A_3E2D;
    localparam bit [63:0] STAR_MULT     = 64'h2545_F491_4F6C_DD1D;

    typedef struct {
        bit [31:0] lo;
        bit [31:0] hi;
        bit [31:0] value;
    } t_bounded_value;

    // tracks generator state and the values the block owes
    class range_scoreboard;
        bit [63:0]      seed_reg;
        bit [63:0]      gen_state;
        t_bounded_value expected_q[$];
        int             checked;
        int             mismatches;
        int             degenerate_cnt;
        int             draw_cnt;
        int             reject_cnt;

        function new();
            seed_reg       = '0;
            gen_state      = '0;
            checked        = 0;
            mismatches     = 0;
            degenerate_cnt = 0;
            draw_cnt       = 0;
            reject_cnt     = 0;
        endfunction

        function void write_seed(bit [63:0] value);
            seed_reg = value;
        endfunction

        function void note_request(bit [31:0] lo, bit [31:0] hi);
            t_bounded_value item;
            bit [63:0]      span;
            bit [63:0]      limit;
            bit [63:0]      x;
            bit [63:0]      m;
            bit [63:0]      fold;
            bit [63:0]      r;
            bit             keep;
            int             i;
            item.lo = lo;
            item.hi = hi;
            if (lo >= hi) begin
                item.value = lo;
                degenerate_cnt++;
            end else begin
                span  = {32'd0, hi} - {32'd0, lo} + 64'd1;
                limit = ((64'd1 << DRAW_BITS) / span) * span;
                do begin
                    // first draw seeds from the folded and mixed entropy word
                    if (gen_state == '0) begin
                        m    = seed_reg;
                        fold = '0;
                        for (i = 0; i < 8; i++) begin
                            fold = (fold << 8) ^ (m & 64'hFF);
                            m    = (m >> 8) ^ (m << 5);
                        end
                        x = (seed_reg ^ fold) + GOLDEN_GAMMA;
                        x = (x ^ (x >> 30)) * MIX_MULT_A;
                        x = (x ^ (x >> 27)) * MIX_MULT_B;
                        x = x ^ (x >> 31);
                        gen_state = (x == '0) ? FALLBACK_SEED : x;
                    end
                    x = gen_state;
                    x ^= x >> 12;
                    x ^= x << 25;
                    x ^= x >> 27;
                    gen_state = x;
                    r = (x * STAR_MULT) & ((64'd1 << DRAW_BITS) - 64'd1);
                    draw_cnt++;
                    keep = (limit == '0) || (r < limit);
                    if (!keep) begin
                        reject_cnt++;
                    end
                end while (!keep);
                item.value = lo + 32'(r % span);
            end
            expected_q.push_back(item);
        endfunction

        function void check_value(logic [31:0] got);
            t_bounded_value item;
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_MAX) begin
                    $display("unexpected result word %h at %0t", got, $time);
                end
                return;
            end
            item = expected_q.pop_front();
            checked++;
            if (got !== item.value) begin
                mismatches++;
                if (mismatches <= REPORT_MAX) begin
                    $display("mismatch at %0t: bounds [%h, %h] expected %h got %h",
                             $time, item.lo, item.hi, item.value, got);
                end
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void close();
            if (expected_q.size() != 0) begin
                mismatches += expected_q.size();
                $display("%0d expected results never arrived", expected_q.size());
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [63:0] i_cfg_wdata;       // entropy_seed
    logic        i_s_axis_tvalid;
    logic        o_s_axis_tready;
    logic [63:0] i_s_axis_tdata;    // [31:0] lower_bound, [63:32] upper_bound
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready;
    logic [31:0] o_m_axis_tdata;    // [31:0] random_value

    bit sender_gaps;
    bit receiver_stalls;
    bit hold_req;
    int cycle_count;

    range_scoreboard sb = new();

    xorshift_uniform_range_generator #(
        .DRAW_BITS(DRAW_BITS)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_s_axis_tvalid(i_s_axis_tvalid),
        .o_s_axis_tready(o_s_axis_tready),
        .i_s_axis_tdata (i_s_axis_tdata),
        .o_m_axis_tvalid(o_m_axis_tvalid),
        .i_m_axis_tready(i_m_axis_tready),
        .o_m_axis_tdata (o_m_axis_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d results outstanding",
                 cycle_count, sb.pending());
        $display("CHECK FAILED");
        $finish;
    end

    // every handshake and register write is observed here
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_we) begin
                sb.write_seed(i_cfg_wdata);
            end
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                sb.note_request(i_s_axis_tdata[31:0], i_s_axis_tdata[63:32]);
            end
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                sb.check_value(o_m_axis_tdata);
            end
        end
    end

    // result side: random stall bursts plus one long hold-off on request
    initial begin
        int n;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                i_m_axis_tready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_req = 1'b0;
            end else if (receiver_stalls && $urandom_range(0, 3) == 0) begin
                i_m_axis_tready = 1'b0;
                n = $urandom_range(1, 8);
                repeat (n - 1) @(negedge i_clk);
            end else begin
                i_m_axis_tready = 1'b1;
            end
        end
    end

    task automatic write_seed_reg(input bit [63:0] value);
        @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_wdata = value;
        @(negedge i_clk);
        i_cfg_we    = 1'b0;
    endtask

    task automatic send_bounds(input bit [31:0] lo, input bit [31:0] hi);
        int gap;
        @(negedge i_clk);
        if (sender_gaps && $urandom_range(0, 3) == 0) begin
            i_s_axis_tvalid = 1'b0;
            gap = $urandom_range(1, 8);
            repeat (gap) @(negedge i_clk);
        end
        i_s_axis_tvalid = 1'b1;
        i_s_axis_tdata  = {hi, lo};
        do @(posedge i_clk); while (!o_s_axis_tready);
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        i_s_axis_tvalid = 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    task automatic random_requests(input int count, input bit idling);
        bit [31:0] lo;
        bit [31:0] hi;
        bit [31:0] a;
        bit [31:0] b;
        bit [31:0] span;
        int        kind;
        int        n;
        for (n = 0; n < count; n++) begin
            if (n % 25 == 0) begin
                sender_gaps     = idling && ($urandom_range(0, 3) != 0);
                receiver_stalls = idling && ($urandom_range(0, 3) != 0);
            end
            kind = $urandom_range(0, 99);
            a    = $urandom;
            b    = $urandom;
            if (kind < 12) begin
                // lower at or above upper, sometimes equal
                lo = (a > b) ? a : b;
                hi = ($urandom_range(0, 3) == 0) ? lo : ((a > b) ? b : a);
            end else if (kind < 40) begin
                span = $urandom_range(1, 300);
                lo   = (a > 32'hFFFF_FFFF - span) ? 32'hFFFF_FFFF - span : a;
                hi   = lo + span;
            end else if (kind < 62) begin
                // ranges of 2^k and 2^k+1: no rejection versus heavy rejection
                span = (32'd1 << $urandom_range(1, 31)) - 32'($urandom_range(0, 1));
                lo   = $urandom_range(0, 32'hFFFF_FFFF - span);
                hi   = lo + span;
            end else begin
                lo = (a < b) ? a : b;
                hi = (a < b) ? b : a;
            end
            send_bounds(lo, hi);
        end
    endtask

    initial begin
        bit [63:0] first_seed;
        int        pick;
        i_rst_n         = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_wdata     = '0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        i_m_axis_tready = 1'b0;
        sender_gaps     = 1'b0;
        receiver_stalls = 1'b0;
        hold_req        = 1'b0;
        cycle_count     = 0;
        repeat (2) @(negedge i_clk);
        i_rst_n = 1'b1;

        // degenerate bounds must neither seed nor advance the generator
        write_seed_reg(64'hFFFF_FFFF_FFFF_FFFF);
        send_bounds(32'h0000_0000, 32'h0000_0000);
        send_bounds(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_bounds(32'hFFFF_FFFF, 32'h0000_0000);
        send_bounds(32'h0000_0005, 32'h0000_0003);
        send_bounds(32'h8000_0000, 32'h7FFF_FFFF);
        wait_drained();

        pick = $urandom_range(0, 2);
        first_seed = (pick == 0) ? 64'd0 :
                     (pick == 1) ? 64'hFFFF_FFFF_FFFF_FFFF : {$urandom, $urandom};
        write_seed_reg(first_seed);
        sender_gaps     = 1'b1;
        receiver_stalls = 1'b1;
        send_bounds(32'h0000_0000, 32'hFFFF_FFFF);
        send_bounds(32'h0000_0001, 32'hFFFF_FFFF);
        send_bounds(32'h0000_0000, 32'hFFFF_FFFE);
        send_bounds(32'h0000_0000, 32'h0000_0001);
        send_bounds(32'hFFFF_FFFE, 32'hFFFF_FFFF);
        send_bounds(32'h0000_0000, 32'h8000_0000);
        send_bounds(32'h7FFF_FFFF, 32'h8000_0001);
        send_bounds(32'h0000_0000, 32'h7FFF_FFFF);
        send_bounds(32'h8000_0000, 32'hFFFF_FFFF);
        send_bounds(32'h0000_0064, 32'h0000_006E);
        send_bounds(32'h5555_5555, 32'hAAAA_AAAA);
        wait_drained();

        // result side blocked while words keep coming, so the input backs up
        hold_req = 1'b1;
        random_requests(30, 1'b1);
        random_requests(150, 1'b1);
        // pause until the block has nothing left to deliver
        wait_drained();
        random_requests(50, 1'b1);
        wait_drained();

        // seed writes after seeding must leave the sequence untouched
        write_seed_reg({$urandom, $urandom});
        random_requests(180, 1'b1);
        wait_drained();

        write_seed_reg(64'd0);
        random_requests(120, 1'b0);
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        sb.close();
        $display("ran %0d requests (%0d with degenerate bounds), %0d draws, %0d rejected",
                 sb.checked, sb.degenerate_cnt, sb.draw_cnt, sb.reject_cnt);
        $display("bounds from single values to the full 32-bit span, %0d mismatches",
                 sb.mismatches);
        if (sb.mismatches == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
